FILE: hw/rtl/lffd_pkg.sv
// shared types and constants for the length-field frame decoder
package lffd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 32;
    localparam int SKIP_W      = 8;
    localparam int LBYTES_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_W       = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BYTES      = 2'd2;

    // configuration reset values
    localparam logic [LEN_W-1:0]    RST_MAX_LEN           = 32'd1048576;
    localparam logic [SKIP_W-1:0]   RST_HEADER_SKIP_BYTES = 8'd0;
    localparam logic [LBYTES_W-1:0] RST_LENGTH_BYTES      = 3'd4;

    localparam logic [LBYTES_W-1:0] LBYTES_MIN = 3'd1;
    localparam logic [LBYTES_W-1:0] LBYTES_MAX = 3'd4;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [LEN_W-1:0]    max_len;
        logic [SKIP_W-1:0]   header_skip_bytes;
        logic [LBYTES_W-1:0] eff_length_bytes;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
        logic              length_error;
    } result_t;

endpackage

FILE: hw/rtl/lffd_cfg.sv
// configuration registers with length-size clamping
module lffd_cfg
    import lffd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    logic [LEN_W-1:0]    max_len_reg;
    logic [SKIP_W-1:0]   skip_reg;
    logic [LBYTES_W-1:0] lbytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= RST_MAX_LEN;
            skip_reg    <= RST_HEADER_SKIP_BYTES;
            lbytes_reg  <= RST_LENGTH_BYTES;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_MAX_LEN:           max_len_reg <= cfg_data;
                CFG_HEADER_SKIP_BYTES: skip_reg    <= cfg_data[SKIP_W-1:0];
                CFG_LENGTH_BYTES:      lbytes_reg  <= cfg_data[LBYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, above four acts as four
    always_comb
    begin
        cfg.max_len           = max_len_reg;
        cfg.header_skip_bytes = skip_reg;
        if (lbytes_reg < LBYTES_MIN)
            cfg.eff_length_bytes = LBYTES_MIN;
        else if (lbytes_reg > LBYTES_MAX)
            cfg.eff_length_bytes = LBYTES_MAX;
        else
            cfg.eff_length_bytes = lbytes_reg;
    end

endmodule

FILE: hw/rtl/lffd_core.sv
// frame phase tracking, length assembly and result generation
module lffd_core
    import lffd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              res_valid,
    output result_t           res
);

    phase_t           phase_reg,  phase_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [LEN_W-1:0] accum_reg,  accum_next;
    logic [LEN_W-1:0] left_reg,   left_next;

    logic [LEN_W-1:0] base_accum;
    logic [CNT_W-1:0] base_count;
    logic [LEN_W-1:0] new_accum;
    logic [CNT_W-1:0] new_count;
    logic [LEN_W-1:0] left_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            accum_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
            left_reg  <= left_next;
        end
    end

    // header byte that falls through starts the length field fresh
    assign base_accum = (phase_reg == PH_HEADER) ? '0 : accum_reg;
    assign base_count = (phase_reg == PH_HEADER) ? '0 : count_reg;
    assign new_accum  = {base_accum[LEN_W-BYTE_W-1:0], data_byte};
    assign new_count  = base_count + CNT_W'(1);
    assign left_dec   = (left_reg != '0) ? left_reg - LEN_W'(1) : left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        accum_next = accum_reg;
        left_next  = left_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (accept)
        begin
            unique case (phase_reg) inside
                PH_ERROR:
                begin
                end
                PH_PAYLOAD:
                begin
                    res_valid        = 1'b1;
                    res.payload_byte = data_byte;
                    res.frame_last   = (left_dec == '0);
                    left_next        = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                        accum_next = '0;
                    end
                end
                PH_HEADER, PH_LENGTH:
                begin
                    if (phase_reg == PH_HEADER && count_reg < cfg.header_skip_bytes)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (new_count < CNT_W'(cfg.eff_length_bytes))
                    begin
                        phase_next = PH_LENGTH;
                        count_next = new_count;
                        accum_next = new_accum;
                    end
                    else if (new_accum == '0 || new_accum > cfg.max_len)
                    begin
                        phase_next       = PH_ERROR;
                        count_next       = new_count;
                        accum_next       = new_accum;
                        res_valid        = 1'b1;
                        res.length_error = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                        count_next = '0;
                        accum_next = new_accum;
                        left_next  = new_accum;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/lffd_out_buf.sv
// output register with one skid entry
module lffd_out_buf
    import lffd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    take;

    assign take      = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // push only arrives while the skid entry is empty
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_next       = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/length_field_frame_decoder.sv
// top level of the length-field frame decoder
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    data_byte
//   output    out        out_valid / out_stall  payload_byte, frame_last, length_error
//   config    in         cfg_wen                cfg_index, cfg_data
//
// one byte request is taken every cycle unless in_stall is high; its result, if any,
// set by the single phase/count update, goes to the output register or skid entry
// reset clears phase, counters and config to their defaults; no clearing pass
// output stall is absorbed by a one-entry skid buffer, so input stall rises
// only when both the output register and the skid entry hold a request
// an invalid length gives one error request, then every byte is dropped until reset
module length_field_frame_decoder
    import lffd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    // byte stream in
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    // results out
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    payload_byte,
    output logic                 frame_last,
    output logic                 length_error
);

    cfg_t    cfg;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    buf_full;

    // skid entry full means the next result could have nowhere to go
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    lffd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // header skip, length assembly, payload pass-through in one step per byte
    lffd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    lffd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign payload_byte = out_data.payload_byte;
    assign frame_last   = out_data.frame_last;
    assign length_error = out_data.length_error;

endmodule

FILE: dv/length_field_frame_decoder_tb.sv
// self-checking testbench for the length-field frame decoder
module length_field_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lffd_pkg::*;

    // register index with no register behind it, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // results pass through the output register, plus a skid entry
    localparam int DRAIN_CYCLES = 4;
    localparam int END_TAIL     = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 1150;
    // bytes kept back for the final stretch without idling
    localparam int QUIET_RESERVE = 80;

    typedef enum logic [0:0] {ROW_BYTE, ROW_REG} row_kind_e;
    // how the expectation of a byte row is formed
    typedef enum logic [1:0] {BY_MODEL, NO_RESULT, TYPED} row_check_e;
    // ways to end the run with a rejected length
    typedef enum logic [1:0] {BAD_ZERO, BAD_ABOVE_MAX, BAD_MAX_ZERO} bad_len_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [LEN_W-1:0]     val;
        row_check_e           how;
        result_t              res;
    } stim_row_t;

    localparam int N_ROWS = 40;

    // directed stimulus, walked in order from reset
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // reset registers: no header, 4-byte length field, length 1
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h01, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'hFF, TYPED, '{8'hFF, 1'b1, 1'b0}},
        // two header bytes, 1-byte length of 2
        '{ROW_REG, CFG_HEADER_SKIP_BYTES, 32'd2, BY_MODEL, '0},
        '{ROW_REG, CFG_LENGTH_BYTES, 32'd1, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'hAA, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h55, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h02, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h00, TYPED, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 32'h80, TYPED, '{8'h80, 1'b1, 1'b0}},
        // header count shrinks while inside the header
        '{ROW_REG, CFG_HEADER_SKIP_BYTES, 32'd3, BY_MODEL, '0},
        '{ROW_REG, CFG_LENGTH_BYTES, 32'd2, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'h11, NO_RESULT, '0},
        '{ROW_REG, CFG_HEADER_SKIP_BYTES, 32'd1, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h01, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h5A, TYPED, '{8'h5A, 1'b1, 1'b0}},
        // length field shrinks from 4 to 3 bytes while being collected
        '{ROW_REG, CFG_HEADER_SKIP_BYTES, 32'd0, BY_MODEL, '0},
        '{ROW_REG, CFG_LENGTH_BYTES, 32'd4, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_REG, CFG_LENGTH_BYTES, 32'd3, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'h02, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'hC3, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'h3C, BY_MODEL, '0},
        // length size 0 acts as 1, smallest maximum
        '{ROW_REG, CFG_LENGTH_BYTES, 32'd0, BY_MODEL, '0},
        '{ROW_REG, CFG_MAX_LEN, 32'd1, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'h01, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h7E, TYPED, '{8'h7E, 1'b1, 1'b0}},
        // length size 7 acts as 4, largest maximum, write to the spare index
        '{ROW_REG, CFG_LENGTH_BYTES, 32'd7, BY_MODEL, '0},
        '{ROW_REG, CFG_MAX_LEN, 32'hFFFF_FFFF, BY_MODEL, '0},
        '{ROW_REG, CFG_UNUSED, 32'h5A5A_A5A5, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h00, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h02, NO_RESULT, '0},
        '{ROW_BYTE, '0, 32'h01, BY_MODEL, '0},
        '{ROW_BYTE, '0, 32'hFE, BY_MODEL, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    data_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 frame_last;
    logic                 length_error;

    // decoder state as the testbench sees it
    phase_t              dec_phase  = PH_HEADER;
    logic [8:0]          dec_count  = '0;
    logic [LEN_W-1:0]    dec_accum  = '0;
    logic [LEN_W-1:0]    dec_left   = '0;
    logic [LEN_W-1:0]    reg_max    = RST_MAX_LEN;
    logic [SKIP_W-1:0]   reg_skip   = RST_HEADER_SKIP_BYTES;
    logic [LBYTES_W-1:0] reg_lbytes = RST_LENGTH_BYTES;

    result_t predicted_results [$];
    int      mismatches  = 0;
    int      bytes_sent  = 0;
    int      idle_cycles = 0;
    bit      quiet       = 1'b0;

    length_field_frame_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .length_error (length_error)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // length field size actually used: 0 counts as 1, above 4 as 4
    function automatic int field_bytes(input logic [LBYTES_W-1:0] lb);
        if (lb < LBYTES_MIN)
            return int'(LBYTES_MIN);
        if (lb > LBYTES_MAX)
            return int'(LBYTES_MAX);
        return int'(lb);
    endfunction

    // advance the decoder state by one byte, returns 1 when it gives a result
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output result_t r);
        r = '0;
        if (dec_phase == PH_ERROR)
            return 1'b0;
        if (dec_phase == PH_PAYLOAD)
        begin
            if (dec_left != 0)
                dec_left = dec_left - 1'b1;
            r.payload_byte = b;
            r.frame_last   = (dec_left == 0);
            if (dec_left == 0)
            begin
                dec_phase = PH_HEADER;
                dec_count = '0;
                dec_accum = '0;
            end
            return 1'b1;
        end
        if (dec_phase == PH_HEADER)
        begin
            if (dec_count < {1'b0, reg_skip})
            begin
                dec_count = dec_count + 1'b1;
                return 1'b0;
            end
            dec_phase = PH_LENGTH;
            dec_count = '0;
            dec_accum = '0;
        end
        // length byte, big-endian
        dec_accum = {dec_accum[LEN_W-BYTE_W-1:0], b};
        dec_count = dec_count + 1'b1;
        if (dec_count < field_bytes(reg_lbytes))
            return 1'b0;
        if (dec_accum == 0 || dec_accum > reg_max)
        begin
            dec_phase      = PH_ERROR;
            r.length_error = 1'b1;
            return 1'b1;
        end
        dec_left  = dec_accum;
        dec_count = '0;
        dec_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // one register write, only issued while no byte is presented and the results have drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] d);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_MAX_LEN:           reg_max    = d;
            CFG_HEADER_SKIP_BYTES: reg_skip   = d[SKIP_W-1:0];
            CFG_LENGTH_BYTES:      reg_lbytes = d[LBYTES_W-1:0];
            default: ;
        endcase
    endtask

    // stop sending and let every predicted result drain
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // present one byte request, wait for its acceptance, record its expectation
    task automatic send_byte(input logic [BYTE_W-1:0] b,
                             input row_check_e how = BY_MODEL,
                             input result_t typed = '0);
        result_t r;
        bit      has;
        int      gap;
        if (!quiet && $urandom_range(0, 11) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        has = decode_byte(b, r);
        if (how == TYPED)
            predicted_results.push_back(typed);
        else if (how == BY_MODEL && has)
            predicted_results.push_back(r);
    endtask

    // big-endian length field at the current field size
    task automatic send_length(input logic [LEN_W-1:0] len);
        for (int i = field_bytes(reg_lbytes) - 1; i >= 0; i--)
            send_byte(len[8*i +: 8]);
    endtask

    // new register setting, then a run of well-formed frames with random content
    task automatic run_phase();
        logic [LEN_W-1:0] d;
        logic [LEN_W-1:0] len;
        longint unsigned  lim;
        int               frames;
        int               cap;
        settle_block();
        case ($urandom_range(0, 5))
            0:       d = 32'd1;
            1:       d = 32'hFFFF_FFFF;
            2:       d = RST_MAX_LEN;
            3, 4:    d = $urandom_range(300, 1);
            default:
            begin
                d = $urandom;
                if (d == 0)
                    d = 32'd1;
            end
        endcase
        write_reg(CFG_MAX_LEN, d);
        // upper bits of the narrow registers sometimes carry junk
        d = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        d[SKIP_W-1:0] = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
        write_reg(CFG_HEADER_SKIP_BYTES, d);
        d = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        d[LBYTES_W-1:0] = 3'($urandom_range(0, 7));
        write_reg(CFG_LENGTH_BYTES, d);
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_UNUSED, $urandom);

        // long headers make frames costly, so only a couple of them
        frames = (reg_skip == 8'd255) ? $urandom_range(1, 2) : $urandom_range(2, 8);
        repeat (frames)
        begin
            lim = reg_max;
            if (field_bytes(reg_lbytes) == 1 && lim > 255)
                lim = 255;
            case ($urandom_range(0, 19))
                0:       cap = 300;
                1, 2, 3: cap = 40;
                default: cap = 8;
            endcase
            if (lim > cap)
                lim = cap;
            // hit the largest accepted length now and then
            len = ($urandom_range(0, 4) == 0) ? lim[31:0] : $urandom_range(lim[31:0], 1);
            repeat (reg_skip) send_byte(8'($urandom));
            send_length(len);
            repeat (len) send_byte(8'($urandom));
        end
    endtask

    // receiver: stall bursts mixed with free-running stretches, none at the end
    initial
    begin
        int stall_run;
        bit stall_on;
        out_stall = 1'b0;
        forever
        begin
            stall_run = $urandom_range(1, 15);
            stall_on  = ($urandom_range(0, 2) == 0);
            repeat (stall_run)
            begin
                @(negedge clk);
                out_stall <= stall_on && !quiet;
            end
        end
    end

    // result checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_results.size() == 0)
                flag_mismatch($sformatf("unexpected result %02h last=%b err=%b",
                                        payload_byte, frame_last, length_error));
            else
            begin
                want = predicted_results.pop_front();
                if (payload_byte !== want.payload_byte)
                    flag_mismatch($sformatf("payload_byte %02h, predicted %02h",
                                            payload_byte, want.payload_byte));
                if (frame_last !== want.frame_last)
                    flag_mismatch($sformatf("frame_last %b, predicted %b",
                                            frame_last, want.frame_last));
                if (length_error !== want.length_error)
                    flag_mismatch($sformatf("length_error %b, predicted %b",
                                            length_error, want.length_error));
            end
        end
    end

    // watchdog: too long without any request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [LEN_W-1:0] d;
        logic [LEN_W-1:0] len;
        longint unsigned  span;
        bad_len_e         bad;
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows; register rows wait for the predicted results to drain first
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_REG)
            begin
                settle_block();
                write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].val);
            end
            else
                send_byte(DIRECTED_ROWS[i].val[BYTE_W-1:0], DIRECTED_ROWS[i].how,
                          DIRECTED_ROWS[i].res);
        end

        // random phases, each starting at a frame boundary with the block drained
        while (bytes_sent < ITEM_TARGET - QUIET_RESERVE)
            run_phase();

        // last stretch at full rate on both sides
        quiet = 1'b1;
        run_phase();

        // a rejected length closes the channel for good, so it comes last
        settle_block();
        write_reg(CFG_HEADER_SKIP_BYTES, $urandom_range(0, 3));
        bad = bad_len_e'($urandom_range(0, 2));
        case (bad)
            BAD_ZERO:
            begin
                write_reg(CFG_LENGTH_BYTES, $urandom_range(0, 7));
                len = '0;
            end
            BAD_ABOVE_MAX:
            begin
                d = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFE
                                                : $urandom_range(32'hFFFF_FFFE, 1);
                write_reg(CFG_MAX_LEN, d);
                write_reg(CFG_LENGTH_BYTES, LEN_W'(LBYTES_MAX));
                len = d + 1'b1;
            end
            default:
            begin
                // maximum of zero: any nonzero length is refused
                write_reg(CFG_MAX_LEN, '0);
                write_reg(CFG_LENGTH_BYTES, $urandom_range(0, 7));
                span = (64'd1 << (8 * field_bytes(reg_lbytes))) - 1;
                len  = $urandom_range(span[31:0], 1);
            end
        endcase
        repeat (reg_skip) send_byte(8'($urandom));
        send_length(len);
        // everything after the error must be swallowed
        repeat (16) send_byte(8'($urandom));

        settle_block();
        repeat (END_TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/lffd_pkg.sv
hw/rtl/lffd_cfg.sv
hw/rtl/lffd_core.sv
hw/rtl/lffd_out_buf.sv
hw/rtl/length_field_frame_decoder.sv
dv/length_field_frame_decoder_tb.sv
